// ===== design/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg: shared constants for the identifier bitmap allocator
// Operation and status codes, bitmap word geometry and register defaults.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PBA_NUM_IDS   = 4096;
  localparam int PBA_WORD_BITS = 64;
  localparam int PBA_BIT_W     = 6;
  localparam int PBA_ID_OUT_W  = 12;
  localparam int PBA_FREE_ID_W = 13;
  localparam int PBA_FLOOR_W   = 12;

  localparam logic [PBA_FLOOR_W-1:0] PBA_FLOOR_RST = 12'd2;
  localparam logic [PBA_WORD_BITS-1:0] PBA_WORD0_RST = 64'h3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STAT_ALLOCATED = 2'd0;
  localparam logic [1:0] STAT_NONE_FREE = 2'd1;
  localparam logic [1:0] STAT_FREED     = 2'd2;
  localparam logic [1:0] STAT_IGNORED   = 2'd3;

endpackage

// ===== design/pba_ram.sv =====
// ----------------------------------------------------------------------------
// pba_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/pid_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// pid_bitmap_allocator: next-fit identifier allocator over a bitmap
// Hands out and releases identifiers kept as one bit each in a word RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per beat. in_tuser[0] is the operation (0 allocate,
//           1 free), in_tdata carries the identifier to release.
//   out_* : one answer per request: out_tdata holds the allocated identifier,
//           out_tuser the status (allocated, none free, freed, ignored).
//   cfg_* : writes the reserved floor; write only while the block is idle.
// Sequence: a free does a RAM read, a write-back and an answer load, in that
//   order. An allocate reads and examines one 64-bit bitmap word at a time
//   (S_SCAN_RD, then S_SCAN_EV), moving on until a word holds a clear bit
//   or, on exhaustion, the scan is back at its start word, and then loads
//   the answer. An ignored free goes straight to the answer load. The scan
//   is bound by the single RAM port pair: each word is read, then examined.
//   One request is in work at a time; the next is taken as soon as the
//   previous answer sits in the output register.
// Reset: a clearing pass writes every bitmap word (identifiers 0 and 1 set,
//   the rest clear), with in_tready low meanwhile.
// Stall: a held answer stays in the output register; one more request is
//   accepted and worked, then the block waits for out_tready.
// ----------------------------------------------------------------------------
module pid_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int NUM_IDS = PBA_NUM_IDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [12:0] free_id
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] given_id
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  localparam int NUM_WORDS = (NUM_IDS + PBA_WORD_BITS - 1) / PBA_WORD_BITS;
  localparam int ID_W      = $clog2(NUM_IDS);
  localparam int WA_W      = ID_W - PBA_BIT_W;
  localparam int CW        = (ID_W + 1 > PBA_FREE_ID_W) ? ID_W + 1 : PBA_FREE_ID_W;
  localparam logic [CW-1:0]   NUM_IDS_C  = CW'(NUM_IDS);
  localparam logic [WA_W-1:0] LAST_WORD  = WA_W'(NUM_WORDS - 1);

  typedef enum logic [6:0] {
    S_CLR     = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_FREE_RD = 7'b0000100,
    S_FREE_WR = 7'b0001000,
    S_SCAN_RD = 7'b0010000,
    S_SCAN_EV = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [WA_W-1:0]           clr_addr_r, clr_addr_nxt;
  logic [PBA_FLOOR_W-1:0]    floor_r;
  logic [ID_W-1:0]           last_r, last_nxt;
  logic [ID_W-1:0]           cur_r, cur_nxt;
  logic [WA_W-1:0]           start_word_r, start_word_nxt;
  logic                      wrapped_r, wrapped_nxt;
  logic [PBA_ID_OUT_W-1:0]   res_id_r, res_id_nxt;
  logic [1:0]                res_stat_r, res_stat_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [PBA_ID_OUT_W-1:0]   out_id_r, out_id_nxt;
  logic [1:0]                out_stat_r, out_stat_nxt;

  logic                      wr_en, rd_en;
  logic [WA_W-1:0]           wr_addr;
  logic [PBA_WORD_BITS-1:0]  wr_data, rd_data;

  logic [WA_W-1:0]           cur_word;
  logic [PBA_BIT_W-1:0]      cur_bit;
  logic [CW-1:0]             floor_c, fid_c, start_c, next_base_c, found_c;
  logic [PBA_WORD_BITS-1:0]  cand;
  logic [PBA_BIT_W-1:0]      sel_idx;
  logic                      sel_hit;
  logic                      in_fire;

  assign cur_word  = cur_r[ID_W-1:PBA_BIT_W];
  assign cur_bit   = cur_r[PBA_BIT_W-1:0];
  assign floor_c   = CW'(floor_r);
  assign fid_c     = CW'(in_tdata[PBA_FREE_ID_W-1:0]);
  assign start_c   = CW'(last_r) + CW'(1);
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Candidate bits: clear, at or above the cursor, and below the top.
  always_comb begin
    for (int b = 0; b < PBA_WORD_BITS; b++) begin
      cand[b] = !rd_data[b] && (PBA_BIT_W'(b) >= cur_bit) &&
                (CW'({cur_word, PBA_BIT_W'(b)}) < NUM_IDS_C);
    end
  end

  always_comb begin
    sel_idx = '0;
    for (int b = PBA_WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        sel_idx = PBA_BIT_W'(b);
      end
    end
    sel_hit = |cand;
  end

  assign found_c     = CW'({cur_word, sel_idx});
  assign next_base_c = CW'({cur_word, PBA_BIT_W'(0)}) + CW'(PBA_WORD_BITS);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    last_nxt       = last_r;
    cur_nxt        = cur_r;
    start_word_nxt = start_word_r;
    wrapped_nxt    = wrapped_r;
    res_id_nxt     = res_id_r;
    res_stat_nxt   = res_stat_r;
    out_valid_nxt  = out_valid_r;
    out_id_nxt     = out_id_r;
    out_stat_nxt   = out_stat_r;
    wr_en          = 1'b0;
    wr_addr        = cur_word;
    wr_data        = rd_data;
    rd_en          = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = (clr_addr_r == '0) ? PBA_WORD0_RST : '0;
        clr_addr_nxt = clr_addr_r + WA_W'(1);
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        res_id_nxt = '0;
        if (in_fire) begin
          if (in_tuser[0] == FUNC_FREE) begin
            if (fid_c >= floor_c && fid_c < NUM_IDS_C) begin
              cur_nxt   = fid_c[ID_W-1:0];
              state_nxt = S_FREE_RD;
            end else begin
              res_stat_nxt = STAT_IGNORED;
              state_nxt    = S_RESP;
            end
          end else if (floor_c >= NUM_IDS_C) begin
            res_stat_nxt = STAT_NONE_FREE;
            state_nxt    = S_RESP;
          end else begin
            // Next-fit: resume one past the last grant, clamp into range.
            if (start_c >= NUM_IDS_C || start_c < floor_c) begin
              cur_nxt = floor_c[ID_W-1:0];
            end else begin
              cur_nxt = start_c[ID_W-1:0];
            end
            start_word_nxt = cur_nxt[ID_W-1:PBA_BIT_W];
            wrapped_nxt    = 1'b0;
            state_nxt      = S_SCAN_RD;
          end
        end
      end
      S_FREE_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        wr_en        = 1'b1;
        wr_data      = rd_data & ~(PBA_WORD_BITS'(1) << cur_bit);
        res_stat_nxt = STAT_FREED;
        state_nxt    = S_RESP;
      end
      S_SCAN_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (sel_hit) begin
          wr_en        = 1'b1;
          wr_data      = rd_data | (PBA_WORD_BITS'(1) << sel_idx);
          last_nxt     = found_c[ID_W-1:0];
          res_id_nxt   = found_c[PBA_ID_OUT_W-1:0];
          res_stat_nxt = STAT_ALLOCATED;
          state_nxt    = S_RESP;
        end else if (wrapped_r && cur_word == start_word_r) begin
          // Every identifier from the start around to it has been visited.
          res_stat_nxt = STAT_NONE_FREE;
          state_nxt    = S_RESP;
        end else if (next_base_c >= NUM_IDS_C) begin
          cur_nxt     = floor_c[ID_W-1:0];
          wrapped_nxt = 1'b1;
          state_nxt   = S_SCAN_RD;
        end else begin
          cur_nxt   = next_base_c[ID_W-1:0];
          state_nxt = S_SCAN_RD;
        end
      end
      S_RESP: begin
        // Hold here while an older answer still waits at the output.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      floor_r     <= PBA_FLOOR_RST;
      last_r      <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      last_r      <= last_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        floor_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_word_r <= start_word_nxt;
    res_id_r     <= res_id_nxt;
    res_stat_r   <= res_stat_nxt;
    out_id_r     <= out_id_nxt;
    out_stat_r   <= out_stat_nxt;
  end

  pba_ram #(
    .WIDTH (PBA_WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cur_word),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_id_r};
  assign out_tuser  = out_stat_r;

endmodule
